/* rtl/core/tmavg_pkg.sv */
`timescale 1ns / 1ps

package tmavg_pkg;

  // Samples dropped by the trimmed mean: the window maximum and minimum.
  localparam int TRIM_DROP = 2;

  // Entries in the queue between the input side and the processing side.
  localparam int QUEUE_DEPTH = 2;

  // Width of the reported fill count.
  localparam int FILL_BITS = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_DONE
  } back_state_t;

endpackage

/* rtl/core/tmavg_queue.sv */
`timescale 1ns / 1ps

module tmavg_queue #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          q_vld,
  output logic signed [SAMPLE_BITS-1:0] q_data,
  input  logic                          q_pop
);

  localparam int DEPTH = tmavg_pkg::QUEUE_DEPTH;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic signed [SAMPLE_BITS-1:0] entry_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic push;
  logic pop;

  assign in_stall = (cnt_r == NW'(DEPTH));
  assign q_vld = (cnt_r != '0);
  assign q_data = entry_r[rd_ptr_r];
  assign push = in_valid && !in_stall;
  assign pop = q_pop && q_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + IW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + IW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_sample;
    end
  end

endmodule

/* rtl/core/tmavg_div.sv */
`timescale 1ns / 1ps

module tmavg_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic ge;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign ge = (shifted >= {1'b0, den_r});
  assign diff = shifted - {1'b0, den_r};
  assign done = done_r;
  assign quo = quo_r;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

/* rtl/core/tmavg_back.sv */
`timescale 1ns / 1ps

module tmavg_back #(
  parameter int WINDOW = 5,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_vld,
  input  logic signed [SAMPLE_BITS-1:0]      q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_trimmed_mean,
  output logic signed [SAMPLE_BITS-1:0]      out_plain_mean,
  output logic [tmavg_pkg::FILL_BITS-1:0]    out_fill_count
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int PW = $clog2(WINDOW);
  localparam int SW = SAMPLE_BITS + $clog2(WINDOW);
  localparam int FB = tmavg_pkg::FILL_BITS;

  tmavg_pkg::back_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic rd_en;
  logic [PW-1:0] rd_addr;
  logic wr_en;
  logic [PW-1:0] wr_addr;

  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic signed [SAMPLE_BITS-1:0] hi_r, hi_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_r, lo_nxt;
  logic signed [SW-1:0] trim_r, trim_nxt;
  logic [PW-1:0] scan_addr_r, scan_addr_nxt;
  logic [CW-1:0] scan_left_r, scan_left_nxt;
  logic cmp_vld_r, cmp_vld_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_trim_r, out_trim_nxt;
  logic signed [SAMPLE_BITS-1:0] out_plain_r, out_plain_nxt;
  logic [FB-1:0] out_fill_r, out_fill_nxt;

  logic full;
  logic [PW:0] slot_sum;
  logic [PW-1:0] slot;
  logic [PW-1:0] ptr_inc;
  logic signed [SW:0] trim_full;
  logic [SW-1:0] sum_mag;
  logic [SW-1:0] trim_mag;
  logic div_start;
  logic plain_done;
  logic trim_done;
  logic [SW-1:0] plain_quo;
  logic [SW-1:0] trim_quo;
  logic [SW-1:0] plain_res;
  logic [SW-1:0] trim_res;
  logic [CW+FB-1:0] count_ext;

  assign full = (count_r == CW'(WINDOW));
  assign slot_sum = (PW+1)'(ptr_r) + (PW+1)'(count_r);
  assign slot = (slot_sum >= (PW+1)'(WINDOW)) ? PW'(slot_sum - (PW+1)'(WINDOW))
                                              : slot_sum[PW-1:0];
  assign ptr_inc = (ptr_r == PW'(WINDOW - 1)) ? '0 : ptr_r + PW'(1);
  assign trim_full = (SW+1)'(sum_r) - (SW+1)'(hi_r) - (SW+1)'(lo_r);
  assign sum_mag = sum_r[SW-1] ? (~$unsigned(sum_r) + SW'(1)) : $unsigned(sum_r);
  assign trim_mag = trim_r[SW-1] ? (~$unsigned(trim_r) + SW'(1)) : $unsigned(trim_r);
  assign plain_res = sum_r[SW-1] ? (~plain_quo + SW'(1)) : plain_quo;
  assign trim_res = trim_r[SW-1] ? (~trim_quo + SW'(1)) : trim_quo;
  assign count_ext = (CW+FB)'(count_r);

  assign out_valid = out_valid_r;
  assign out_trimmed_mean = out_trim_r;
  assign out_plain_mean = out_plain_r;
  assign out_fill_count = out_fill_r;

  tmavg_div #(
    .NUM_W(SW),
    .DEN_W(CW)
  ) u_div_plain (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .num(sum_mag),
    .den(count_r),
    .done(plain_done),
    .quo(plain_quo)
  );

  tmavg_div #(
    .NUM_W(SW),
    .DEN_W(CW)
  ) u_div_trim (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .num(trim_mag),
    .den(count_r - CW'(tmavg_pkg::TRIM_DROP)),
    .done(trim_done),
    .quo(trim_quo)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt = ptr_r;
    sum_nxt = sum_r;
    smp_nxt = smp_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    trim_nxt = trim_r;
    scan_addr_nxt = scan_addr_r;
    scan_left_nxt = scan_left_r;
    cmp_vld_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_trim_nxt = out_trim_r;
    out_plain_nxt = out_plain_r;
    out_fill_nxt = out_fill_r;
    q_pop = 1'b0;
    rd_en = 1'b0;
    rd_addr = ptr_r;
    wr_en = 1'b0;
    wr_addr = slot;
    div_start = 1'b0;

    case (state_r)
      tmavg_pkg::ST_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          smp_nxt = q_data;
          rd_en = 1'b1;
          rd_addr = ptr_r;
          state_nxt = tmavg_pkg::ST_UPDATE;
        end
      end
      tmavg_pkg::ST_UPDATE: begin
        wr_en = 1'b1;
        if (full) begin
          wr_addr = ptr_r;
          sum_nxt = sum_r - SW'(rd_data_r) + SW'(smp_r);
          ptr_nxt = ptr_inc;
        end else begin
          wr_addr = slot;
          sum_nxt = sum_r + SW'(smp_r);
          count_nxt = count_r + CW'(1);
        end
        hi_nxt = smp_r;
        lo_nxt = smp_r;
        scan_addr_nxt = full ? ptr_inc : ptr_r;
        scan_left_nxt = full ? count_r : count_r + CW'(1);
        state_nxt = tmavg_pkg::ST_SCAN;
      end
      tmavg_pkg::ST_SCAN: begin
        if (cmp_vld_r) begin
          if (rd_data_r > hi_r) begin
            hi_nxt = rd_data_r;
          end
          if (rd_data_r < lo_r) begin
            lo_nxt = rd_data_r;
          end
        end
        if (scan_left_r != '0) begin
          rd_en = 1'b1;
          rd_addr = scan_addr_r;
          scan_addr_nxt = (scan_addr_r == PW'(WINDOW - 1)) ? '0 : scan_addr_r + PW'(1);
          scan_left_nxt = scan_left_r - CW'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          state_nxt = tmavg_pkg::ST_PREP;
        end
      end
      tmavg_pkg::ST_PREP: begin
        trim_nxt = $signed(trim_full[SW-1:0]);
        state_nxt = tmavg_pkg::ST_START;
      end
      tmavg_pkg::ST_START: begin
        div_start = 1'b1;
        state_nxt = tmavg_pkg::ST_WAIT;
      end
      tmavg_pkg::ST_WAIT: begin
        if (plain_done && trim_done) begin
          state_nxt = tmavg_pkg::ST_DONE;
        end
      end
      tmavg_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_plain_nxt = $signed(plain_res[SAMPLE_BITS-1:0]);
          out_trim_nxt = (count_r <= CW'(tmavg_pkg::TRIM_DROP))
                         ? $signed(plain_res[SAMPLE_BITS-1:0])
                         : $signed(trim_res[SAMPLE_BITS-1:0]);
          out_fill_nxt = count_ext[FB-1:0];
          state_nxt = tmavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tmavg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmavg_pkg::ST_IDLE;
      count_r <= '0;
      ptr_r <= '0;
      sum_r <= '0;
      scan_left_r <= '0;
      cmp_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r <= ptr_nxt;
      sum_r <= sum_nxt;
      scan_left_r <= scan_left_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    trim_r <= trim_nxt;
    scan_addr_r <= scan_addr_nxt;
    out_trim_r <= out_trim_nxt;
    out_plain_r <= out_plain_nxt;
    out_fill_r <= out_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/trimmed_moving_average.sv */
`timescale 1ns / 1ps

// Moving average over the last WINDOW signed Q16.8 samples, giving for each request
// the plain mean and the mean with the window maximum and minimum removed; both
// divisions truncate toward zero, and with two samples or fewer held the trimmed mean
// equals the plain mean. A two-entry queue takes requests while the processing side
// works, and one result register holds a finished result while the next request is
// already being processed. Each request is handled by a scan of the window through the single
// read port of the sample memory, one entry per cycle, followed by two bit-serial dividers
// that run in parallel and produce one quotient bit per cycle.
module trimmed_moving_average #(
  parameter int WINDOW = 5,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [SAMPLE_BITS-1:0]   out_trimmed_mean,
  output logic signed [SAMPLE_BITS-1:0]   out_plain_mean,
  output logic [tmavg_pkg::FILL_BITS-1:0] out_fill_count
);

  logic q_vld;
  logic signed [SAMPLE_BITS-1:0] q_data;
  logic q_pop;

  tmavg_queue #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .q_vld(q_vld),
    .q_data(q_data),
    .q_pop(q_pop)
  );

  tmavg_back #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_vld(q_vld),
    .q_data(q_data),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trimmed_mean(out_trimmed_mean),
    .out_plain_mean(out_plain_mean),
    .out_fill_count(out_fill_count)
  );

endmodule

/* rtl/core/tmavg_checker.sv */
`timescale 1ns / 1ps

module tmavg_assertions #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [SAMPLE_BITS-1:0]   out_trimmed_mean,
  input logic signed [SAMPLE_BITS-1:0]   out_plain_mean,
  input logic [tmavg_pkg::FILL_BITS-1:0] out_fill_count
);

  localparam int FB = tmavg_pkg::FILL_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_plain_mean) && $stable(out_trimmed_mean)
                               && $stable(out_fill_count))
    else $error("stalled result changed");

  a_few_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fill_count == FB'(1) || out_fill_count == FB'(2))
      |-> out_trimmed_mean == out_plain_mean)
    else $error("trimmed mean differs from plain mean with two samples or fewer");

  a_first_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind trimmed_moving_average tmavg_assertions #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_tmavg_assertions (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_trimmed_mean(out_trimmed_mean),
  .out_plain_mean(out_plain_mean),
  .out_fill_count(out_fill_count)
);

/* tb/tmavg_checker.sv */
`timescale 1ns / 1ps

module tmavg_checker #(
  parameter int WINDOW = 5,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic signed [SAMPLE_BITS-1:0]   out_trimmed_mean,
  input  logic signed [SAMPLE_BITS-1:0]   out_plain_mean,
  input  logic [tmavg_pkg::FILL_BITS-1:0] out_fill_count,
  output int                              failures,
  output int                              checked,
  output int                              pending
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]   trimmed;
    logic signed [SAMPLE_BITS-1:0]   plain;
    logic [tmavg_pkg::FILL_BITS-1:0] fill;
  } mean_pair_t;

  longint     window_samples [WINDOW];
  int         held;
  int         oldest;
  longint     sample_total;
  mean_pair_t expected_means [int];
  int         wr_idx;
  int         rd_idx;

  task automatic predict_means(input logic signed [SAMPLE_BITS-1:0] sample);
    longint     value;
    longint     hi;
    longint     lo;
    longint     slot_value;
    longint     plain;
    longint     trimmed;
    mean_pair_t pair;
    value = sample;
    if (held < WINDOW) begin
      window_samples[(oldest + held) % WINDOW] = value;
      held++;
    end else begin
      sample_total -= window_samples[oldest];
      window_samples[oldest] = value;
      oldest = (oldest + 1) % WINDOW;
    end
    sample_total += value;
    hi = value;
    lo = value;
    for (int i = 0; i < held; i++) begin
      slot_value = window_samples[(oldest + i) % WINDOW];
      if (slot_value > hi) hi = slot_value;
      if (slot_value < lo) lo = slot_value;
    end
    plain = sample_total / held;
    if (held <= tmavg_pkg::TRIM_DROP) begin
      trimmed = plain;
    end else begin
      trimmed = (sample_total - hi - lo) / (held - tmavg_pkg::TRIM_DROP);
    end
    pair.trimmed = trimmed[SAMPLE_BITS-1:0];
    pair.plain = plain[SAMPLE_BITS-1:0];
    pair.fill = held[tmavg_pkg::FILL_BITS-1:0];
    expected_means[wr_idx] = pair;
    wr_idx++;
  endtask

  task automatic compare_means();
    mean_pair_t pair;
    if (wr_idx == rd_idx) begin
      $error("Result with no request outstanding: trimmed_mean %0d, plain_mean %0d, fill %0d",
             out_trimmed_mean, out_plain_mean, out_fill_count);
      failures++;
    end else begin
      pair = expected_means[rd_idx];
      expected_means.delete(rd_idx);
      rd_idx++;
      checked++;
      if (out_trimmed_mean !== pair.trimmed) begin
        $error("trimmed_mean: expected %0d, actual %0d", pair.trimmed, out_trimmed_mean);
        failures++;
      end
      if (out_plain_mean !== pair.plain) begin
        $error("plain_mean: expected %0d, actual %0d", pair.plain, out_plain_mean);
        failures++;
      end
      if (out_fill_count !== pair.fill) begin
        $error("fill_count: expected %0d, actual %0d", pair.fill, out_fill_count);
        failures++;
      end
    end
  endtask

  initial begin
    failures = 0;
    checked = 0;
    pending = 0;
    held = 0;
    oldest = 0;
    sample_total = 0;
    wr_idx = 0;
    rd_idx = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      held = 0;
      oldest = 0;
      sample_total = 0;
      expected_means.delete();
      wr_idx = 0;
      rd_idx = 0;
    end else begin
      if (in_valid && !in_stall) predict_means(in_sample);
      if (out_valid && !out_stall) compare_means();
    end
    pending = wr_idx - rd_idx;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int WINDOW = 5;
  localparam int SAMPLE_BITS = 24;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_ITEMS = 500;
  localparam int SETTLE_CYCLES = 100;

  typedef logic signed [SAMPLE_BITS-1:0] speed_t;

  localparam int SPEED_MAX = 8388607;
  localparam int SPEED_MIN = -8388608;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  speed_t                          in_sample;
  logic                            out_valid;
  logic                            out_stall;
  speed_t                          out_trimmed_mean;
  speed_t                          out_plain_mean;
  logic [tmavg_pkg::FILL_BITS-1:0] out_fill_count;

  int failures;
  int checked;
  int pending;
  int sent;
  int idle_pct;
  int stall_pct;
  int cycle_count = 0;

  int idle_plan  [4] = '{0, 83, 0, 37};
  int stall_plan [4] = '{0, 0, 83, 37};

  int opening_samples [24] = '{
    1, -3, 2, SPEED_MIN, SPEED_MAX,
    SPEED_MAX, SPEED_MAX, SPEED_MAX, SPEED_MAX,
    SPEED_MIN, SPEED_MIN, SPEED_MIN, SPEED_MIN, SPEED_MIN,
    0, -1, -1, -2, SPEED_MAX, SPEED_MIN, 5, -7, 255, -256
  };

  always #5 clk = ~clk;

  trimmed_moving_average #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trimmed_mean(out_trimmed_mean),
    .out_plain_mean(out_plain_mean),
    .out_fill_count(out_fill_count)
  );

  tmavg_checker #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_trimmed_mean(out_trimmed_mean),
    .out_plain_mean(out_plain_mean),
    .out_fill_count(out_fill_count),
    .failures(failures),
    .checked(checked),
    .pending(pending)
  );

  always @(negedge clk) begin
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic speed_t random_speed();
    speed_t value;
    case ($urandom_range(9))
      5, 6: value = speed_t'(int'($urandom_range(2047)) - 1024);
      7: value = speed_t'(SPEED_MAX - int'($urandom_range(15)));
      8: value = speed_t'(SPEED_MIN + int'($urandom_range(15)));
      default: value = speed_t'($urandom);
    endcase
    return value;
  endfunction

  // Entered and left at a falling edge, so valid stays high between back-to-back requests.
  task automatic send_sample(input speed_t sample);
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      in_sample <= speed_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (opening_samples[i]) send_sample(speed_t'(opening_samples[i]));
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      repeat (PHASE_ITEMS) send_sample(random_speed());
      drain_results();
    end
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples through four idle and stall mixes; %0d results checked.",
             sent, checked);
    if (failures == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
